### src/sacm_pkg.sv
// ----------------------------------------------------------------------------
// sacm_pkg: shared types and constants for the cache hit/miss model
// Opcode and outcome codes, controller states, register map and the
// flag group passed from the set update logic to the top level.
// ----------------------------------------------------------------------------
package sacm_pkg;

  localparam int TAG_W = 64;
  localparam int CNT_W = 32;
  localparam int WCNT_W = 5;
  localparam int SHIFT_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_IGNORED = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_LOOK  = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    REG_SET_BITS    = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } lookup_flags_t;

endpackage

### src/set_assoc_cache_hit_miss_model.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_model: set-associative cache hit/miss/eviction model
// Tracks tags and ages of every line and running hit, miss and eviction
// totals for a stream of load, store, modify and fetch accesses.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2**SET_INDEX_BITS sets (64 at the default)
// of the set memory to zero, one set per cycle; busy is high during the
// sweep and register writes are taken as usual. Each access then runs as
// follows: the accept cycle splits the address and launches the read of the
// whole set from the single set memory, the next cycle compares all ways,
// ages and replaces, and writes the set back. busy stays high for that
// lookup cycle, so a new access is accepted only once the lookup is done and
// always reads a set that is already written back. The result beat appears
// on outcome and the totals with done high for exactly one cycle, the cycle
// after the lookup; the receiver must take it then. Instruction fetches pass
// through the same accept and lookup cycles without writing the set memory.
// Configuration is meant to change only while no access is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss_model #(
  parameter int SET_INDEX_BITS = 6,
  parameter int MAX_WAYS       = 8,
  parameter int AGE_WIDTH      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // access command
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [sacm_pkg::TAG_W-1:0]  address,
  // result beat
  output logic                        done,
  output logic [1:0]                  outcome,
  output logic [sacm_pkg::CNT_W-1:0]  hits_total,
  output logic [sacm_pkg::CNT_W-1:0]  misses_total,
  output logic [sacm_pkg::CNT_W-1:0]  evictions_total,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sacm_pkg::*;

  localparam int NUM_SETS = 1 << SET_INDEX_BITS;
  localparam int SET_AW   = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
  localparam int ROW_W    = MAX_WAYS * (1 + TAG_W + AGE_WIDTH);

  // configuration registers
  logic [2:0] set_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_in_use;

  // control
  state_t state, state_next;
  logic   accept;
  logic   mem_we;
  logic [SET_AW-1:0] clear_idx;
  logic              clear_last;

  // access captured at accept
  opcode_t             look_op;
  logic [TAG_W-1:0]    look_tag;
  logic [SET_AW-1:0]   look_set;
  logic [MAX_WAYS-1:0] look_active;

  // address split
  logic [TAG_W-1:0]    above;
  logic [SHIFT_W-1:0]  s_eff;
  logic [TAG_W-1:0]    acc_tag;
  logic [SET_AW-1:0]   acc_set;
  logic [WCNT_W-1:0]   ways_eff;
  logic [MAX_WAYS-1:0] acc_active;

  // set memory
  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  logic [MAX_WAYS-1:0]                 rd_valid, wr_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0]      rd_tag, wr_tag;
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  rd_age, wr_age;
  lookup_flags_t                       flags;

  // counters
  logic [CNT_W-1:0] hit_counter, hit_counter_next;
  logic [CNT_W-1:0] miss_counter, miss_counter_next;
  logic [CNT_W-1:0] eviction_counter, eviction_counter_next;
  logic [CNT_W-1:0] hit_pre;
  outcome_t         outcome_reg, outcome_next;

  // --------------------------------------------------------------------------
  // register port: one register per word, always ready
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      offset_bits <= '0;
      ways_in_use <= 4'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SET_BITS:    set_bits    <= pwdata[2:0];
        REG_OFFSET_BITS: offset_bits <= pwdata[5:0];
        REG_WAYS_IN_USE: ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SET_BITS:    prdata = {29'd0, set_bits};
      REG_OFFSET_BITS: prdata = {26'd0, offset_bits};
      REG_WAYS_IN_USE: prdata = {28'd0, ways_in_use};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // address split: offset, then set index clipped to the memory, then tag
  // --------------------------------------------------------------------------
  always_comb begin
    above = address >> offset_bits;
    s_eff = ({1'b0, set_bits} > SHIFT_W'(SET_INDEX_BITS)) ? SHIFT_W'(SET_INDEX_BITS)
                                                         : {1'b0, set_bits};
    acc_tag = above >> s_eff;
    for (int i = 0; i < SET_AW; i++) begin
      acc_set[i] = above[i] & (SHIFT_W'(i) < s_eff);
    end
    // way count of zero acts as one, above the build limit acts as the limit
    if (ways_in_use == '0) begin
      ways_eff = WCNT_W'(1);
    end else if ({1'b0, ways_in_use} > WCNT_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = {1'b0, ways_in_use};
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      acc_active[j] = WCNT_W'(j) < ways_eff;
    end
  end

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  assign accept     = start && !busy;
  assign clear_last = (clear_idx == SET_AW'(NUM_SETS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    case (state)
      ST_CLEAR: begin
        busy   = 1'b1;
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        mem_we = 1'b0;
      end
      ST_LOOK: begin
        busy   = 1'b1;
        mem_we = (look_op != OP_IFETCH);
      end
      default: begin
        busy   = 1'b1;
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_idx <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_LOOK);
      if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      look_op     <= opcode_t'(opcode);
      look_tag    <= acc_tag;
      look_set    <= acc_set;
      look_active <= acc_active;
    end
  end

  // --------------------------------------------------------------------------
  // set memory: registered read at accept, write back in the lookup cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= mem[acc_set];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (state == ST_CLEAR) begin
        mem[clear_idx] <= '0;
      end else begin
        mem[look_set] <= wr_row;
      end
    end
  end

  assign {rd_valid, rd_tag, rd_age} = rd_row;
  assign wr_row = {wr_valid, wr_tag, wr_age};

  sacm_set_update #(
    .MAX_WAYS  (MAX_WAYS),
    .AGE_WIDTH (AGE_WIDTH)
  ) u_update (
    .active    (look_active),
    .look_tag  (look_tag),
    .valid_in  (rd_valid),
    .tag_in    (rd_tag),
    .age_in    (rd_age),
    .valid_out (wr_valid),
    .tag_out   (wr_tag),
    .age_out   (wr_age),
    .flags     (flags)
  );

  // --------------------------------------------------------------------------
  // totals: modify counts its extra hit first, all counters saturate
  // --------------------------------------------------------------------------
  always_comb begin
    hit_counter_next      = hit_counter;
    miss_counter_next     = miss_counter;
    eviction_counter_next = eviction_counter;
    outcome_next          = OUT_IGNORED;
    hit_pre = (look_op == OP_MODIFY && hit_counter != CNT_MAX) ? hit_counter + 1'b1
                                                               : hit_counter;
    if (look_op != OP_IFETCH) begin
      hit_counter_next = hit_pre;
      if (flags.hit) begin
        outcome_next = OUT_HIT;
        if (hit_pre != CNT_MAX) hit_counter_next = hit_pre + 1'b1;
      end else begin
        outcome_next = flags.evict ? OUT_EVICT : OUT_FILL;
        if (miss_counter != CNT_MAX) miss_counter_next = miss_counter + 1'b1;
        if (flags.evict && eviction_counter != CNT_MAX) begin
          eviction_counter_next = eviction_counter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter      <= '0;
      miss_counter     <= '0;
      eviction_counter <= '0;
      outcome_reg      <= OUT_IGNORED;
    end else if (state == ST_LOOK) begin
      hit_counter      <= hit_counter_next;
      miss_counter     <= miss_counter_next;
      eviction_counter <= eviction_counter_next;
      outcome_reg      <= outcome_next;
    end
  end

  assign outcome         = outcome_reg;
  assign hits_total      = hit_counter;
  assign misses_total    = miss_counter;
  assign evictions_total = eviction_counter;

`ifndef ASSERT_OFF
  // a result beat only ever follows a lookup cycle
  a_done_after_look: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_LOOK))
    else $error("result beat without lookup");

  // an accepted access blocks the next one for its lookup cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("access accepted during lookup");

  // a real access resolves to exactly one of hit, fill and evict
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK && look_op != OP_IFETCH) |->
      $onehot({flags.hit, flags.fill, flags.evict}))
    else $error("lookup outcome not unique");

  // the hit total never goes backward
  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hit_counter >= $past(hit_counter)))
    else $error("hit total decreased");
`endif

endmodule

### src/sacm_set_update.sv
// ----------------------------------------------------------------------------
// sacm_set_update: lookup and replacement for one cache set
// Compares all ways against the tag, ages the ways passed over, picks the
// way to fill or evict and builds the row to write back.
// ----------------------------------------------------------------------------
module sacm_set_update #(
  parameter int MAX_WAYS  = 8,
  parameter int AGE_WIDTH = 16
) (
  input  logic [MAX_WAYS-1:0]                      active,
  input  logic [sacm_pkg::TAG_W-1:0]               look_tag,
  input  logic [MAX_WAYS-1:0]                      valid_in,
  input  logic [MAX_WAYS-1:0][sacm_pkg::TAG_W-1:0] tag_in,
  input  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]       age_in,
  output logic [MAX_WAYS-1:0]                      valid_out,
  output logic [MAX_WAYS-1:0][sacm_pkg::TAG_W-1:0] tag_out,
  output logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]       age_out,
  output sacm_pkg::lookup_flags_t                  flags
);
  import sacm_pkg::*;

  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0] aged;
  logic [MAX_WAYS-1:0]                match;
  logic [MAX_WAYS-1:0]                reach;
  logic [MAX_WAYS-1:0]                hit_oh;
  logic [MAX_WAYS-1:0]                empty_oh;
  logic [MAX_WAYS-1:0]                victim_oh;
  logic                               found;
  logic [AGE_WIDTH-1:0]               best;

  // per-way compare and saturating age
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      aged[j]  = (age_in[j] == '1) ? age_in[j] : age_in[j] + 1'b1;
      match[j] = active[j] & valid_in[j] & (tag_in[j] == look_tag);
    end
  end

  // first hit in way order, highest empty way, last oldest way
  always_comb begin
    found     = 1'b0;
    hit_oh    = '0;
    reach     = '0;
    empty_oh  = '0;
    victim_oh = '0;
    best      = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      reach[j]  = ~found;
      hit_oh[j] = match[j] & ~found;
      if (match[j]) begin
        found = 1'b1;
      end
      if (active[j] && !valid_in[j]) begin
        empty_oh    = '0;
        empty_oh[j] = 1'b1;
      end
      if (active[j] && aged[j] >= best) begin
        best         = aged[j];
        victim_oh    = '0;
        victim_oh[j] = 1'b1;
      end
    end
  end

  always_comb begin
    flags.hit   = found;
    flags.fill  = ~found & (|empty_oh);
    flags.evict = ~found & ~(|empty_oh);
  end

  // write-back row
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      valid_out[j] = valid_in[j];
      tag_out[j]   = tag_in[j];
      age_out[j]   = age_in[j];
      if (active[j] && valid_in[j] && reach[j] && !match[j]) begin
        age_out[j] = aged[j];
      end
      if (hit_oh[j]) begin
        age_out[j] = '0;
      end
      if ((flags.fill && empty_oh[j]) || (flags.evict && victim_oh[j])) begin
        valid_out[j] = 1'b1;
        tag_out[j]   = look_tag;
        age_out[j]   = '0;
      end
    end
  end

endmodule

### bench/cache_tally_pkg.sv
// ----------------------------------------------------------------------------
// cache_tally_pkg: expected hit/miss/eviction tallies for the cache model
// Keeps its own copy of the line state and registers, works out the result
// beat of every accepted access and checks the beats that come back.
// ----------------------------------------------------------------------------
package cache_tally_pkg;

  import sacm_pkg::*;

  localparam int SETS_LOG  = 6;
  localparam int NUM_WAYS  = 8;
  localparam int NUM_LINES = (1 << SETS_LOG) * NUM_WAYS;
  localparam logic [15:0] AGE_TOP = 16'hFFFF;

  typedef struct packed {
    outcome_t          outcome;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  evicts;
  } tally_t;

  class cache_tally;
    int unsigned set_bits    = 0;
    int unsigned offset_bits = 0;
    int unsigned way_count   = 1;

    bit          present [NUM_LINES];
    logic [63:0] tags    [NUM_LINES];
    logic [15:0] ages    [NUM_LINES];
    logic [CNT_W-1:0] hits   = '0;
    logic [CNT_W-1:0] misses = '0;
    logic [CNT_W-1:0] evicts = '0;

    tally_t      due_tallies[$];
    int unsigned mismatches = 0;

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_SET_BITS:    set_bits    = val & 32'h7;
        REG_OFFSET_BITS: offset_bits = val & 32'h3F;
        REG_WAYS_IN_USE: way_count   = val & 32'hF;
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // one access: scan the ways in order, then fill or replace on a miss
    function void note_access(opcode_t op, logic [63:0] addr);
      int unsigned s_eff, ways, set_idx, base, empty_way, victim, j;
      logic [63:0] above, tag;
      logic [15:0] oldest;
      bit hit, have_empty;
      tally_t t;
      if (op == OP_IFETCH) begin
        t.outcome = OUT_IGNORED;
      end else begin
        s_eff = (set_bits > SETS_LOG) ? SETS_LOG : set_bits;
        ways = (way_count < 1) ? 1 : (way_count > NUM_WAYS) ? NUM_WAYS : way_count;
        above = addr >> offset_bits;
        set_idx = int'(above & ((64'd1 << s_eff) - 64'd1));
        tag = above >> s_eff;
        base = set_idx * NUM_WAYS;
        hit = 0;
        have_empty = 0;
        empty_way = 0;
        if (op == OP_MODIFY) hits = bump(hits);
        for (j = 0; j < ways && !hit; j++) begin
          if (!present[base+j]) begin
            have_empty = 1;
            empty_way = j;
          end else if (tags[base+j] == tag) begin
            hit = 1;
            ages[base+j] = '0;
          end else if (ages[base+j] != AGE_TOP) begin
            ages[base+j] = ages[base+j] + 1'b1;
          end
        end
        if (hit) begin
          hits = bump(hits);
          t.outcome = OUT_HIT;
        end else begin
          if (have_empty) begin
            victim = empty_way;
            t.outcome = OUT_FILL;
          end else begin
            // oldest way, the last one on ties
            victim = 0;
            oldest = '0;
            for (j = 0; j < ways; j++) begin
              if (ages[base+j] >= oldest) begin
                oldest = ages[base+j];
                victim = j;
              end
            end
            evicts = bump(evicts);
            t.outcome = OUT_EVICT;
          end
          present[base+victim] = 1;
          tags[base+victim] = tag;
          ages[base+victim] = '0;
          misses = bump(misses);
        end
      end
      t.hits = hits;
      t.misses = misses;
      t.evicts = evicts;
      due_tallies.push_back(t);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_tally(logic [1:0] outcome, logic [CNT_W-1:0] h,
                              logic [CNT_W-1:0] m, logic [CNT_W-1:0] e);
      tally_t exp;
      if (due_tallies.size() == 0) begin
        report($sformatf("result beat with nothing outstanding: outcome %0d hits %0d misses %0d evictions %0d",
                         outcome, h, m, e));
        return;
      end
      exp = due_tallies.pop_front();
      if (exp.outcome !== outcome || exp.hits !== h || exp.misses !== m ||
          exp.evicts !== e)
        report($sformatf("exp outcome %0d hits %0d misses %0d evictions %0d, got %0d %0d %0d %0d",
                         exp.outcome, exp.hits, exp.misses, exp.evicts, outcome, h, m, e));
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the set-associative cache hit/miss model
// Drives access beats and register writes, predicts each result beat with
// its own copy of the cache state and checks every beat as it comes out.
// ----------------------------------------------------------------------------
module tb_top;

  import sacm_pkg::*;
  import cache_tally_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        opcode;
  logic [TAG_W-1:0]  address;
  logic              done;
  logic [1:0]        outcome;
  logic [CNT_W-1:0]  hits_total;
  logic [CNT_W-1:0]  misses_total;
  logic [CNT_W-1:0]  evictions_total;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cache_tally model;
  bit         calm;   // set while a stretch runs with no sender gaps

  set_assoc_cache_hit_miss_model dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .address         (address),
    .done            (done),
    .outcome         (outcome),
    .hits_total      (hits_total),
    .misses_total    (misses_total),
    .evictions_total (evictions_total),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // result beats last one cycle and cannot be held off: take each one here
  always @(posedge clk) begin
    if (!rst && done) model.check_tally(outcome, hits_total, misses_total, evictions_total);
  end

  // one access beat; entered and left at a falling edge, start left high
  task automatic send_access(input opcode_t op, input logic [63:0] addr);
    if (!calm && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start   <= 1'b1;
    opcode  <= op;
    address <= addr;
    do @(posedge clk); while (busy);
    model.note_access(op, addr);
    @(negedge clk);
  endtask

  // register write with a setup and an enable phase, only while nothing is in flight
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // idle gap so a following write starts on a later edge
    @(negedge clk);
  endtask

  // wait out every outstanding beat, plus the lookup and output latency
  task automatic settle();
    while (model.due_tallies.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  // tag above set index above offset; bits shifted past bit 63 just drop
  function automatic logic [63:0] make_address(int unsigned s_eff, int unsigned off,
                                               int unsigned set_idx, logic [63:0] tag);
    logic [63:0] low_mask;
    low_mask = (64'd1 << off) - 64'd1;
    return (tag << (s_eff + off)) | (64'(set_idx) << off) | ({$urandom, $urandom} & low_mask);
  endfunction

  // one setting of the registers and a run of random accesses under it
  task automatic run_phase(input int unsigned sbits, input int unsigned obits,
                           input int unsigned wcnt, input int unsigned count,
                           input bit no_gaps);
    int unsigned s_eff, ways, pool, set_idx, n, pick;
    logic [63:0] tag_base, addr;
    opcode_t op;
    write_reg(REG_SET_BITS, sbits);
    write_reg(REG_OFFSET_BITS, obits);
    write_reg(REG_WAYS_IN_USE, wcnt);
    s_eff = (sbits > SETS_LOG) ? SETS_LOG : sbits;
    ways = (wcnt < 1) ? 1 : (wcnt > NUM_WAYS) ? NUM_WAYS : wcnt;
    pool = ways + 2;   // a few more tags than ways, so sets keep thrashing
    tag_base = {$urandom, $urandom};
    calm = no_gaps;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        addr = {$urandom, $urandom};
      end else begin
        if ($urandom_range(3) == 0) set_idx = $urandom_range((1 << s_eff) - 1);
        else set_idx = $urandom_range(((1 << s_eff) - 1) < 3 ? ((1 << s_eff) - 1) : 3);
        addr = make_address(s_eff, obits, set_idx, tag_base + $urandom_range(pool - 1));
      end
      if ($urandom_range(9) == 0) op = OP_IFETCH;
      else op = opcode_t'($urandom_range(2));
      send_access(op, addr);
    end
    calm = 1'b0;
    start <= 1'b0;
    settle();
  endtask

  initial begin
    model = new;
    calm = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_LOAD;
    address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset registers, one way in the only set
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, '1);
    send_access(OP_MODIFY, '1);
    send_access(OP_IFETCH, '1);
    send_access(OP_STORE, 64'd0);
    send_access(OP_IFETCH, 64'd0);
    start <= 1'b0;
    settle();

    // directed: two sets of two ways, 16-byte lines
    write_reg(REG_SET_BITS, 32'd1);
    write_reg(REG_OFFSET_BITS, 32'd4);
    write_reg(REG_WAYS_IN_USE, 32'd2);
    send_access(OP_LOAD, 64'h000);    // fills the highest empty way
    send_access(OP_STORE, 64'h020);   // fills the other way
    send_access(OP_LOAD, 64'h00C);    // hit past an aging way
    send_access(OP_MODIFY, 64'h040);  // full set: oldest way replaced
    send_access(OP_MODIFY, 64'h04F);  // modify hit counts twice
    send_access(OP_LOAD, 64'h010);
    send_access(OP_LOAD, 64'h01F);
    send_access(OP_STORE, 64'h030);
    send_access(OP_LOAD, 64'h050);
    send_access(OP_IFETCH, 64'h050);
    send_access(OP_LOAD, 64'h010);
    send_access(OP_STORE, '1);
    send_access(OP_LOAD, 64'h8000_0000_0000_0000);
    send_access(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    start <= 1'b0;
    settle();

    // random phases; oversized set count and way count, wide offsets among them
    run_phase(2, 4, 4, 120, 1'b0);
    run_phase(0, 0, 1, 100, 1'b0);
    run_phase(6, 6, 8, 130, 1'b1);
    run_phase(7, 3, 15, 110, 1'b0);
    run_phase(3, 63, 0, 80, 1'b0);
    run_phase(6, 58, 8, 100, 1'b0);
    run_phase(1, 32, 2, 110, 1'b0);
    run_phase(5, 12, 8, 120, 1'b0);
    run_phase(4, 60, 3, 90, 1'b0);
    run_phase(2, 1, 5, 150, 1'b0);

    if (model.mismatches == 0 && model.due_tallies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
